// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every clock outside reset
`define ATE_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check that a condition is followed by another in the next cycle
`define ATE_NEXT(lbl, cond, conseq, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (conseq)) \
    else $error(msg);

`endif

// ===== src/ate_pkg.sv =====
package ate_pkg;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned IW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned WW    = ((CW > 6) ? CW : 6) + 1;

  localparam logic [6:0] CAP_RESET = 7'd64;

  typedef logic signed [31:0] word_t;

  typedef enum logic [3:0] {
    K_APPEND    = 4'd0,
    K_INSERT    = 4'd1,
    K_DELETE    = 4'd2,
    K_GET       = 4'd3,
    K_SET       = 4'd4,
    K_SEARCH    = 4'd5,
    K_BINSEARCH = 4'd6,
    K_SORTED    = 4'd7,
    K_MAX       = 4'd8,
    K_MIN       = 4'd9,
    K_SUM       = 4'd10,
    K_REVERSE   = 4'd11,
    K_IS_SORTED = 4'd12
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_BADIDX   = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_EMPTY    = 3'd4
  } status_e;

  typedef struct packed {
    logic [3:0] kind;
    logic [5:0] position;
    word_t      operand;
  } in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [5:0] where_found;
    word_t      result_value;
  } out_t;

  typedef struct packed {
    logic shift;
    logic push;
    logic pop;
  } cell_ctrl_t;

endpackage

// ===== src/array_table_engine_top.sv =====
// Channel | Signals                             | Beat
// in      | in_valid_i, in_ready_o, in_data_i   | kind, position, operand
// out     | out_valid_o, out_ready_i, out_data_o| status, where_found, result_value
// cfg     | cfg_we_i, cfg_data_i                | capacity
// An item is accepted in S_IDLE, rotates the cell ring once in S_RUN and is delivered from S_FIN;
// reverse and sorted insert take two rotations, binary search up to log2(DEPTH)+1.
// Errors, full and empty cases go from S_IDLE straight to S_FIN without rotating.
// Reset clears the count and sets capacity to 64; the entries keep no reset value.
// A new beat is taken once the previous result is loaded into the output register, even if it is stalled.
module array_table_engine_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ate_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ate_pkg::out_t out_data_o,
  input  logic          cfg_we_i,
  input  logic [6:0]    cfg_data_i
);
  import ate_pkg::*;
  `include "assert_macros.svh"

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]    state_q, state_d;
  logic [6:0]    cap_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          out_valid_q, out_valid_d;
  out_t          out_q, out_d;

  kind_e         kind_q, kind_d;
  logic [WW-1:0] pos_q, pos_d;
  word_t         opnd_q, opnd_d;
  logic [IW-1:0] step_q, step_d;
  logic          pass_q, pass_d;
  logic          found_q, found_d;
  logic          swap_q, swap_d;
  logic          err_q, err_d;
  status_e       err_st_q, err_st_d;
  word_t         carry_q, carry_d;
  word_t         val_q, val_d;
  word_t         best_q, best_d;
  word_t         acc_q, acc_d;
  logic [WW-1:0] bidx_q, bidx_d;
  logic [WW-1:0] where_q, where_d;
  logic [WW-1:0] ins_q, ins_d;
  logic [WW-1:0] lo_q, lo_d;
  logic [WW-1:0] hi_q, hi_d;

  cell_ctrl_t    ctrl;
  word_t         tail, head, look, top;
  out_t          res;

  logic [WW-1:0] cnt_w, lim_w, i_w, pos_in, mid_w;
  logic [WW:0]   msum;
  logic          full, last, in_cnt, nxt_in, do_ins, better;

  ate_chain u_chain (
    .clk_i (clk_i),
    .ctrl_i(ctrl),
    .tail_i(tail),
    .push_i(head),
    .head_o(head),
    .look_o(look),
    .top_o (top)
  );

  assign cnt_w  = WW'(cnt_q);
  assign lim_w  = (WW'(cap_q) < WW'(DEPTH)) ? WW'(cap_q) : WW'(DEPTH);
  assign full   = cnt_w >= lim_w;
  assign i_w    = WW'(step_q);
  assign pos_in = WW'(in_data_i.position);
  assign last   = step_q == IW'(DEPTH - 1);
  assign in_cnt = i_w < cnt_w;
  assign nxt_in = (i_w + WW'(1)) < cnt_w;
  assign msum   = {1'b0, lo_q} + {1'b0, hi_q} - (WW+1)'(1);
  assign mid_w  = msum[WW:1];
  assign better = (kind_q == K_MAX) ? (best_q < head) : (head < best_q);

  always_comb begin
    res = '0;
    if (err_q) begin
      res.status = err_st_q;
    end else begin
      unique case (kind_q)
        K_APPEND, K_INSERT, K_SORTED: begin
          res.where_found  = ins_q[5:0];
          res.result_value = opnd_q;
        end
        K_DELETE, K_GET: begin
          res.where_found  = pos_q[5:0];
          res.result_value = val_q;
        end
        K_SET: res.where_found = pos_q[5:0];
        K_SEARCH, K_BINSEARCH: begin
          if (found_q) begin
            res.where_found  = where_q[5:0];
            res.result_value = opnd_q;
          end else begin
            res.status = ST_NOTFOUND;
          end
        end
        K_MAX, K_MIN: begin
          res.where_found  = bidx_q[5:0];
          res.result_value = best_q;
        end
        K_SUM:       res.result_value = acc_q;
        K_IS_SORTED: res.result_value = found_q ? 32'sd0 : 32'sd1;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    kind_d      = kind_q;
    pos_d       = pos_q;
    opnd_d      = opnd_q;
    step_d      = step_q;
    pass_d      = pass_q;
    found_d     = found_q;
    swap_d      = swap_q;
    err_d       = err_q;
    err_st_d    = err_st_q;
    carry_d     = carry_q;
    val_d       = val_q;
    best_d      = best_q;
    acc_d       = acc_q;
    bidx_d      = bidx_q;
    where_d     = where_q;
    ins_d       = ins_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    ctrl        = '0;
    tail        = head;
    do_ins      = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          kind_d   = kind_e'(in_data_i.kind);
          pos_d    = pos_in;
          opnd_d   = in_data_i.operand;
          step_d   = '0;
          pass_d   = 1'b0;
          found_d  = 1'b0;
          swap_d   = 1'b0;
          acc_d    = '0;
          val_d    = '0;
          where_d  = '0;
          bidx_d   = '0;
          lo_d     = '0;
          hi_d     = cnt_w;
          ins_d    = '0;
          err_d    = 1'b0;
          err_st_d = ST_OK;
          unique case (kind_e'(in_data_i.kind))
            K_APPEND: begin
              ins_d = cnt_w;
              if (full) begin
                err_d    = 1'b1;
                err_st_d = ST_FULL;
              end
            end
            K_INSERT: begin
              ins_d = pos_in;
              if (pos_in > cnt_w) begin
                err_d    = 1'b1;
                err_st_d = ST_BADIDX;
              end else if (full) begin
                err_d    = 1'b1;
                err_st_d = ST_FULL;
              end
            end
            K_DELETE, K_GET, K_SET: begin
              if (pos_in >= cnt_w) begin
                err_d    = 1'b1;
                err_st_d = ST_BADIDX;
              end
            end
            K_SORTED: begin
              if (full) begin
                err_d    = 1'b1;
                err_st_d = ST_FULL;
              end
            end
            K_MAX, K_MIN, K_SUM: begin
              if (cnt_q == '0) begin
                err_d    = 1'b1;
                err_st_d = ST_EMPTY;
              end
            end
            K_SEARCH, K_BINSEARCH, K_REVERSE, K_IS_SORTED: ;
            default: err_d = 1'b1;
          endcase
          state_d = err_d ? S_FIN : S_RUN;
        end
      end

      S_RUN: begin
        ctrl.shift = 1'b1;
        unique case (kind_q)
          K_APPEND, K_INSERT: do_ins = 1'b1;
          K_SORTED: begin
            if (pass_q) begin
              do_ins = 1'b1;
            end else if (in_cnt && !(opnd_q < head)) begin
              ins_d = i_w + WW'(1);
            end
          end
          K_DELETE: begin
            if (i_w >= pos_q) tail = look;
            if (i_w == pos_q) val_d = head;
          end
          K_GET: begin
            if (i_w == pos_q) val_d = head;
          end
          K_SET: begin
            if (i_w == pos_q) tail = opnd_q;
          end
          K_SEARCH: begin
            if (swap_q) begin
              tail   = carry_q;
              swap_d = 1'b0;
            end else if (!found_q) begin
              if ((step_q == '0) && (cnt_q != '0) && (head == opnd_q)) begin
                found_d = 1'b1;
                where_d = '0;
              end else if (nxt_in && (look == opnd_q)) begin
                tail    = opnd_q;
                carry_d = head;
                swap_d  = 1'b1;
                found_d = 1'b1;
                where_d = i_w;
              end
            end
          end
          K_BINSEARCH: begin
            if (!found_q && (lo_q < hi_q) && (i_w == mid_w)) begin
              priority if (head == opnd_q) begin
                found_d = 1'b1;
                where_d = mid_w;
              end else if (opnd_q < head) begin
                hi_d = mid_w;
              end else begin
                lo_d = mid_w + WW'(1);
              end
            end
          end
          K_MAX, K_MIN: begin
            if (step_q == '0) begin
              best_d = head;
              bidx_d = '0;
            end else if (in_cnt && better) begin
              best_d = head;
              bidx_d = i_w;
            end
          end
          K_SUM: begin
            if (in_cnt) acc_d = acc_q + head;
          end
          K_REVERSE: begin
            if (!pass_q) begin
              ctrl.push = in_cnt;
            end else if (in_cnt) begin
              tail     = top;
              ctrl.pop = 1'b1;
            end
          end
          K_IS_SORTED: begin
            if (nxt_in && (look < head)) found_d = 1'b1;
          end
          default: ;
        endcase

        if (do_ins) begin
          priority if (i_w < ins_q) begin
            tail = head;
          end else if (i_w == ins_q) begin
            tail = opnd_q;
          end else begin
            tail = carry_q;
          end
          carry_d = head;
        end

        step_d = last ? '0 : step_q + IW'(1);
        if (last) begin
          priority if (((kind_q == K_REVERSE) || (kind_q == K_SORTED)) && !pass_q) begin
            pass_d = 1'b1;
          end else if ((kind_q == K_BINSEARCH) && !found_d && (lo_d < hi_d)) begin
            state_d = S_RUN;
          end else begin
            state_d = S_FIN;
          end
        end
      end

      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d       = res;
          state_d     = S_IDLE;
          if (!err_q) begin
            unique case (kind_q)
              K_APPEND, K_INSERT, K_SORTED: cnt_d = cnt_q + CW'(1);
              K_DELETE:                     cnt_d = cnt_q - CW'(1);
              default: ;
            endcase
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cap_q       <= CAP_RESET;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) cap_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q    <= out_d;
    kind_q   <= kind_d;
    pos_q    <= pos_d;
    opnd_q   <= opnd_d;
    step_q   <= step_d;
    pass_q   <= pass_d;
    found_q  <= found_d;
    swap_q   <= swap_d;
    err_q    <= err_d;
    err_st_q <= err_st_d;
    carry_q  <= carry_d;
    val_q    <= val_d;
    best_q   <= best_d;
    acc_q    <= acc_d;
    bidx_q   <= bidx_d;
    where_q  <= where_d;
    ins_q    <= ins_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ATE_CHECK(a_cnt_range, cnt_q <= CW'(DEPTH), "count beyond depth")
  `ATE_CHECK(a_ring_aligned, ((state_q == S_RUN) && (state_d == S_FIN)) |-> last,
             "item left the ring before a full rotation")
  `ATE_NEXT(a_fin_delivers, (state_q == S_FIN) && (!out_valid_q || out_ready_i),
            (state_q == S_IDLE) && out_valid_q, "finished item not delivered")
  `ATE_CHECK(a_aux_exclusive, !(ctrl.push && ctrl.pop), "push and pop together")

endmodule

// ===== src/ate_cell.sv =====
module ate_cell (
  input  logic                clk_i,
  input  ate_pkg::cell_ctrl_t ctrl_i,
  input  ate_pkg::word_t      main_next_i,
  input  ate_pkg::word_t      aux_left_i,
  input  ate_pkg::word_t      aux_right_i,
  output ate_pkg::word_t      main_o,
  output ate_pkg::word_t      aux_o
);
  import ate_pkg::*;

  word_t main_q, main_d;
  word_t aux_q, aux_d;

  always_comb begin
    main_d = ctrl_i.shift ? main_next_i : main_q;
    priority if (ctrl_i.push) begin
      aux_d = aux_left_i;
    end else if (ctrl_i.pop) begin
      aux_d = aux_right_i;
    end else begin
      aux_d = aux_q;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    aux_q  <= aux_d;
  end

  assign main_o = main_q;
  assign aux_o  = aux_q;

endmodule

// ===== src/ate_chain.sv =====
module ate_chain (
  input  logic                clk_i,
  input  ate_pkg::cell_ctrl_t ctrl_i,
  input  ate_pkg::word_t      tail_i,
  input  ate_pkg::word_t      push_i,
  output ate_pkg::word_t      head_o,
  output ate_pkg::word_t      look_o,
  output ate_pkg::word_t      top_o
);
  import ate_pkg::*;

  word_t main_w [DEPTH];
  word_t aux_w  [DEPTH];

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    word_t nxt, lft, rgt;
    if (k == DEPTH - 1) begin : g_last
      assign nxt = tail_i;
      assign rgt = '0;
    end else begin : g_mid
      assign nxt = main_w[k+1];
      assign rgt = aux_w[k+1];
    end
    if (k == 0) begin : g_first
      assign lft = push_i;
    end else begin : g_rest
      assign lft = aux_w[k-1];
    end
    ate_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl_i),
      .main_next_i(nxt),
      .aux_left_i (lft),
      .aux_right_i(rgt),
      .main_o     (main_w[k]),
      .aux_o      (aux_w[k])
    );
  end

  assign head_o = main_w[0];
  assign look_o = main_w[1];
  assign top_o  = aux_w[0];

endmodule
